@@ rtl/core/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // field widths
  localparam int FUNC_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int CADDR_W  = 11;
  localparam int CELL_W   = 16;
  localparam int COLOUR_W = 4;
  localparam int ATTR_W   = 2 * COLOUR_W;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

  localparam int TAB_STEP = 8;

  // cell value after reset: blank, grey on black
  localparam logic [CELL_W-1:0] CELL_RESET = 16'h0720;

  // register reset values
  localparam logic [COLOUR_W-1:0] FG_RESET = 4'd7;
  localparam logic [COLOUR_W-1:0] BG_RESET = 4'd0;

  // register index (byte address bit 2)
  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [CHAR_W-1:0]  char_byte;
    logic [CADDR_W-1:0] cell_address;
  } in_item_t;

  typedef struct packed {
    logic [CADDR_W-1:0] cursor_index;
    logic [CELL_W-1:0]  cell_word;
  } out_item_t;

  // what a store sweep writes
  typedef enum logic [1:0] {
    FILL_RESET,
    FILL_BLANK,
    FILL_SCROLL
  } fill_sel_t;

  typedef struct packed {
    logic      load;       // latch the accepted input word
    logic      exec_put;   // write character, move cursor
    logic      home;       // cursor to top left
    logic      rd_issue;   // read one cell for a read op
    logic      sweep_run;  // step the store sweep
    fill_sel_t fill_sel;
    logic      out_load;   // load the output register
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              need_scroll;
    logic              sweep_last;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/tcw_dp.sv @@
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath: screen store, cursor, sweep engine and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_dp
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dp_cmd_t           cmd,
  output dp_sts_t                sts,
  input  wire in_item_t          in_data,
  input  wire logic [ATTR_W-1:0] attr,
  output out_item_t              out_data
);

  localparam int CELL_COUNT   = COLUMNS * ROWS;
  localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;
  localparam int CELL_AW      = $clog2(CELL_COUNT);
  localparam int CW           = $clog2(COLUMNS);
  localparam int RW           = $clog2(ROWS);
  localparam int AXW          = ((CELL_AW > CADDR_W) ? CELL_AW : CADDR_W) + 1;

  localparam logic [CELL_AW-1:0] COLS_C   = CELL_AW'(COLUMNS);
  localparam logic [CELL_AW-1:0] LAST_C   = CELL_AW'(CELL_COUNT - 1);
  localparam logic [CELL_AW-1:0] SCROLL_C = CELL_AW'(SCROLL_CELLS);

  logic [CELL_W-1:0]  mem_r [CELL_COUNT];
  logic [CELL_W-1:0]  rd_q_r;

  in_item_t           item_r;
  logic [CW-1:0]      col_r;
  logic [RW-1:0]      row_r;
  logic [CELL_AW-1:0] ptr_r;
  logic               wr_en_r;
  logic [CELL_AW-1:0] wr_addr_r;
  logic               wr_copy_r;
  out_item_t          out_data_r;

  logic [CW:0]        col_x;
  logic [RW:0]        row_x;
  logic [RW-1:0]      row_nxt;
  logic               need_scroll;
  logic               printable;
  logic [CELL_AW-1:0] cur_idx;
  logic [AXW-1:0]     idx_x;
  logic [AXW-1:0]     addr_x;
  logic               addr_ok;
  logic [CELL_W-1:0]  blank;
  logic               mem_we;
  logic [CELL_AW-1:0] mem_wa;
  logic [CELL_W-1:0]  mem_wd;
  logic               mem_re;
  logic [CELL_AW-1:0] mem_ra;
  logic               sweep_rd;

  assign printable = (item_r.char_byte >= CH_BLANK);
  assign blank     = {attr, CH_BLANK};
  assign cur_idx   = CELL_AW'(row_r) * COLS_C + CELL_AW'(col_r);
  assign idx_x     = AXW'(cur_idx);
  assign addr_x    = AXW'(item_r.cell_address);
  assign addr_ok   = (addr_x < AXW'(CELL_COUNT));

  // cursor motion for the latched character
  always_comb begin
    col_x = (CW+1)'(col_r);
    row_x = (RW+1)'(row_r);
    if (printable) begin
      col_x = col_x + (CW+1)'(1);
    end else begin
      case (item_r.char_byte)
        CH_BS: begin
          if (col_r != '0) col_x = col_x - (CW+1)'(1);
        end
        CH_TAB: col_x = (col_x + (CW+1)'(TAB_STEP)) & ~((CW+1)'(TAB_STEP - 1));
        CH_CR:  col_x = '0;
        CH_LF: begin
          col_x = '0;
          row_x = row_x + (RW+1)'(1);
        end
        default: ;
      endcase
    end
    if (col_x >= (CW+1)'(COLUMNS)) begin
      col_x = '0;
      row_x = row_x + (RW+1)'(1);
    end
    need_scroll = (row_x >= (RW+1)'(ROWS));
    row_nxt     = need_scroll ? RW'(ROWS - 1) : row_x[RW-1:0];
  end

  // store ports: sweep write stage has priority, it never meets a put
  assign sweep_rd = cmd.sweep_run && (cmd.fill_sel == FILL_SCROLL) && (ptr_r < SCROLL_C);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_addr_r;
    mem_wd = blank;
    if (wr_en_r) begin
      mem_we = 1'b1;
      unique case (cmd.fill_sel)
        FILL_RESET:  mem_wd = CELL_RESET;
        FILL_BLANK:  mem_wd = blank;
        FILL_SCROLL: mem_wd = wr_copy_r ? rd_q_r : blank;
        default:     mem_wd = blank;
      endcase
    end else if (cmd.exec_put && printable) begin
      mem_we = 1'b1;
      mem_wa = cur_idx;
      mem_wd = {attr, item_r.char_byte};
    end
    mem_re = sweep_rd || (cmd.rd_issue && addr_ok);
    mem_ra = cmd.rd_issue ? addr_x[CELL_AW-1:0] : (ptr_r + COLS_C);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_wa] <= mem_wd;
    if (mem_re) rd_q_r <= mem_r[mem_ra];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    wr_addr_r <= ptr_r;
    wr_copy_r <= (ptr_r < SCROLL_C);
    if (cmd.out_load) begin
      out_data_r.cursor_index <= idx_x[CADDR_W-1:0];
      out_data_r.cell_word    <= ((item_r.func == FUNC_READ) && addr_ok) ? rd_q_r : '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      ptr_r   <= '0;
      wr_en_r <= 1'b0;
    end else begin
      wr_en_r <= cmd.sweep_run;
      ptr_r   <= cmd.sweep_run ? (ptr_r + CELL_AW'(1)) : '0;
      if (cmd.home) begin
        col_r <= '0;
        row_r <= '0;
      end else if (cmd.exec_put) begin
        col_r <= col_x[CW-1:0];
        row_r <= row_nxt;
      end
    end
  end

  assign sts.func        = item_r.func;
  assign sts.need_scroll = need_scroll;
  assign sts.sweep_last  = (ptr_r == LAST_C);
  assign out_data        = out_data_r;

`ifndef SYNTHESIS
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_r} < (CW+1)'(COLUMNS)) && ({1'b0, row_r} < (RW+1)'(ROWS)))
    else $error("cursor outside the screen");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en_r && cmd.exec_put))
    else $error("sweep write collides with character write");

  a_ptr_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.sweep_run |=> (ptr_r == '0))
    else $error("sweep pointer not rewound");
`endif

endmodule

`default_nettype wire

@@ rtl/core/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller: sequences one word at a time and the store sweeps.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t    state_r;
  fill_sel_t mode_r;
  logic      out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.fill_sel  = mode_r;
    cmd.load      = (state_r == S_IDLE) && in_valid;
    cmd.sweep_run = (state_r == S_SWEEP);
    if (state_r == S_EXEC) begin
      case (sts.func)
        FUNC_PUT:   cmd.exec_put = 1'b1;
        FUNC_CLEAR: cmd.home     = 1'b1;
        FUNC_READ:  cmd.rd_issue = 1'b1;
        default:    ;
      endcase
    end
    cmd.out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;     // clearing pass over the store first
      mode_r      <= FILL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_DONE;
          if (sts.func == FUNC_CLEAR) begin
            mode_r  <= FILL_BLANK;
            state_r <= S_SWEEP;
          end else if ((sts.func == FUNC_PUT) && sts.need_scroll) begin
            mode_r  <= FILL_SCROLL;
            state_r <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (sts.sweep_last) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          state_r <= (mode_r == FILL_RESET) ? S_IDLE : S_DONE;
        end
        S_DONE: begin
          if (cmd.out_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_EXEC))
    else $error("accepted word not executed");

  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SWEEP) && sts.sweep_last) |=> (state_r == S_DRAIN))
    else $error("sweep ran past the last cell");

  a_scroll_start: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EXEC) && (sts.func == FUNC_PUT) && sts.need_scroll)
      |=> ((state_r == S_SWEEP) && (mode_r == FILL_SCROLL)))
    else $error("scroll not started");
`endif

endmodule

`default_nettype wire

@@ rtl/core/text_console_writer_core.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text console engine: COLUMNS x ROWS cell store with cursor.
// ----------------------------------------------------------------------------
// One word at a time. A put, read or no-op word is taken in the idle state,
// executed in the exec state and its result loaded into the output register
// in the done state; the next word is taken back in the idle state. A clear,
// and a put that runs off the bottom row and scrolls, add a sweep over all
// COLUMNS*ROWS cells and a drain state, through the single write port of
// the cell store: a scroll copies one cell per cycle through a
// read-then-write pipeline and blanks the new bottom row on the same pass.
// After reset a clearing pass over all COLUMNS*ROWS cells loads every cell
// with 0x0720; in_stall stays high during it, while register writes are
// taken as usual. The result register lets a finished word wait on
// out_stall while the next one is already accepted and executed.
`default_nettype none

module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,  // 8..128
  parameter int ROWS    = DEF_ROWS      // 2..64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input words
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_item_t           in_data,
  // result words
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_item_t               out_data,
  // register port
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [PADDR_W-1:0] cfg_paddr,
  input  wire logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0]      cfg_prdata,
  output logic                    cfg_pready
);

  logic [COLOUR_W-1:0] fg_r;
  logic [COLOUR_W-1:0] bg_r;
  logic                cfg_wr;
  dp_cmd_t             cmd;
  dp_sts_t             sts;

  // register file: fg at 0x0, bg at 0x4; low address bits ignored
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= FG_RESET;
      bg_r <= BG_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_FG:  fg_r <= cfg_pwdata[COLOUR_W-1:0];
        REG_BG:  bg_r <= cfg_pwdata[COLOUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_FG:  cfg_prdata = PDATA_W'(fg_r);
      REG_BG:  cfg_prdata = PDATA_W'(bg_r);
      default: cfg_prdata = '0;
    endcase
  end

  // sequencing
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // store, cursor and result register; attribute is bg:fg
  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .attr     ({bg_r, fg_r}),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ============================================================================
// tb_top: bench for text_console_writer_core
// Drives put, clear, read and no-op words into the console engine with a
// bursty sender and a stalling receiver. Each result word is checked
// against a typed value or a cycle-free model of the screen store and
// cursor. Colour registers are changed between phases over the APB port.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  // geometry under test, shared by the DUT and the screen model
  localparam int COLS  = DEF_COLUMNS;
  localparam int ROWS  = DEF_ROWS;
  localparam int CELLS = COLS * ROWS;

  // func 3 is unused by the block and must behave as a no-op
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  // the stall limit covers a scroll or clear sweep, the longest receiver
  // hold and the longest sender gap, many times over
  localparam int HOLD_CYCLES  = 600;
  localparam int STUCK_LIMIT  = 16000;
  localparam int TAIL_CYCLES  = 40;
  localparam int PHASES       = 6;
  localparam int PHASE_WORDS  = 300;

  logic clk;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data  = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic               cfg_psel    = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite  = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr   = '0;
  logic [PDATA_W-1:0] cfg_pwdata  = '0;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  text_console_writer_core #(
    .COLUMNS (COLS),
    .ROWS    (ROWS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Screen model: cell store, cursor and colours as the block should hold
  // them after every accepted word.
  // --------------------------------------------------------------------------
  logic [CELL_W-1:0]   screen_img [CELLS];
  int                  cur_col;
  int                  cur_row;
  logic [COLOUR_W-1:0] attr_fg;
  logic [COLOUR_W-1:0] attr_bg;

  // result words still owed by the DUT, oldest first
  out_item_t console_replies [$];

  int n_words, n_results, n_scrolls, n_clears, n_reads, n_reads_off, n_faults;

  function automatic logic [CELL_W-1:0] blank_cell();
    return {attr_bg, attr_fg, CH_BLANK};
  endfunction

  function automatic void screen_reset();
    for (int i = 0; i < CELLS; i++) screen_img[i] = CELL_RESET;
    cur_col = 0;
    cur_row = 0;
    attr_fg = FG_RESET;
    attr_bg = BG_RESET;
  endfunction

  // shift everything up one row, blank the bottom row, park on it
  function automatic void scroll_screen();
    for (int i = 0; i < (ROWS - 1) * COLS; i++) screen_img[i] = screen_img[i + COLS];
    for (int i = (ROWS - 1) * COLS; i < CELLS; i++) screen_img[i] = blank_cell();
    cur_row = ROWS - 1;
    n_scrolls++;
  endfunction

  function automatic void put_byte(logic [CHAR_W-1:0] ch);
    if (ch >= CH_BLANK) begin
      // everything from space up prints, 0x7F and high codes included
      screen_img[cur_row * COLS + cur_col] = {attr_bg, attr_fg, ch};
      cur_col++;
    end else if (ch == CH_BS) begin
      if (cur_col != 0) cur_col--;
    end else if (ch == CH_TAB) begin
      cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
    end else if (ch == CH_CR) begin
      cur_col = 0;
    end else if (ch == CH_LF) begin
      cur_col = 0;
      cur_row++;
    end
    // a tab can overshoot the edge too; it wraps like a printed byte
    if (cur_col >= COLS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= ROWS) scroll_screen();
  endfunction

  // applies one accepted word to the model and returns the result it owes
  function automatic out_item_t console_step(in_item_t w);
    out_item_t r;
    r.cell_word = '0;
    case (w.func)
      FUNC_PUT: put_byte(w.char_byte);
      FUNC_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_img[i] = blank_cell();
        cur_col = 0;
        cur_row = 0;
        n_clears++;
      end
      FUNC_READ: begin
        n_reads++;
        if (w.cell_address < CELLS) r.cell_word = screen_img[w.cell_address];
        else n_reads_off++;
      end
      default: ;
    endcase
    r.cursor_index = CADDR_W'(cur_row * COLS + cur_col);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed words. Rows with a typed result carry values that follow
  // directly from reset state and the default grey-on-black attribute;
  // reps repeats the word and the typed value applies to the last one.
  // --------------------------------------------------------------------------
  typedef struct packed {
    in_item_t   word;
    logic [3:0] reps;
    logic       typed;
    out_item_t  res;
  } probe_t;

  localparam int PROBES = 19;

  probe_t probes [PROBES] = '{
    '{'{FUNC_READ,  8'h00,    11'd0},    4'd1, 1'b1, '{11'd0,   CELL_RESET}},
    '{'{FUNC_READ,  8'hFF,    11'd1999}, 4'd1, 1'b1, '{11'd0,   CELL_RESET}},
    // read past the last cell: zero, nothing moves
    '{'{FUNC_READ,  8'h00,    11'h7FF},  4'd1, 1'b1, '{11'd0,   16'h0000}},
    '{'{FUNC_NOP,   8'hFF,    11'h7FF},  4'd1, 1'b1, '{11'd0,   16'h0000}},
    '{'{FUNC_PUT,   CH_BLANK, 11'h7FF},  4'd1, 1'b1, '{11'd1,   16'h0000}},
    '{'{FUNC_PUT,   CH_BS,    11'd0},    4'd1, 1'b1, '{11'd0,   16'h0000}},
    // backspace already at column zero stays put
    '{'{FUNC_PUT,   CH_BS,    11'd0},    4'd1, 1'b1, '{11'd0,   16'h0000}},
    '{'{FUNC_PUT,   8'hFF,    11'd0},    4'd1, 1'b1, '{11'd1,   16'h0000}},
    '{'{FUNC_READ,  8'h00,    11'd0},    4'd1, 1'b1, '{11'd1,   16'h07FF}},
    // control bytes with no meaning are dropped
    '{'{FUNC_PUT,   8'h00,    11'd0},    4'd1, 1'b1, '{11'd1,   16'h0000}},
    '{'{FUNC_PUT,   8'h1F,    11'd0},    4'd1, 1'b1, '{11'd1,   16'h0000}},
    '{'{FUNC_PUT,   8'h7F,    11'd0},    4'd1, 1'b1, '{11'd2,   16'h0000}},
    '{'{FUNC_READ,  8'h00,    11'd1},    4'd1, 1'b1, '{11'd2,   16'h077F}},
    '{'{FUNC_PUT,   CH_CR,    11'd0},    4'd1, 1'b1, '{11'd0,   16'h0000}},
    '{'{FUNC_PUT,   CH_LF,    11'd0},    4'd1, 1'b1, '{11'd80,  16'h0000}},
    '{'{FUNC_PUT,   CH_TAB,   11'd0},    4'd1, 1'b1, '{11'd88,  16'h0000}},
    // eight more stops reach column 72, the ninth runs off the edge
    '{'{FUNC_PUT,   CH_TAB,   11'd0},    4'd9, 1'b1, '{11'd160, 16'h0000}},
    '{'{FUNC_CLEAR, 8'h00,    11'd0},    4'd1, 1'b1, '{11'd0,   16'h0000}},
    '{'{FUNC_READ,  8'h00,    11'd80},   4'd1, 1'b1, '{11'd0,   CELL_RESET}}
  };

  // --------------------------------------------------------------------------
  // Random words: mostly text with line control, some reads, rare clears.
  // --------------------------------------------------------------------------
  function automatic in_item_t make_word();
    in_item_t w;
    int pick;
    int here;
    int back;
    w.func         = FUNC_PUT;
    w.char_byte    = CHAR_W'($urandom());
    w.cell_address = CADDR_W'($urandom());
    pick = $urandom_range(0, 999);
    if (pick < 7) begin
      w.func = FUNC_CLEAR;  // a full sweep each, keep them rare
    end else if (pick < 17) begin
      w.func = FUNC_NOP;
    end else if (pick < 140) begin
      w.func = FUNC_READ;
      pick = $urandom_range(0, 9);
      here = cur_row * COLS + cur_col;
      back = $urandom_range(0, 2);
      // recently written cells, anywhere in the store, or past its end
      if (pick < 4) w.cell_address = CADDR_W'((here > back) ? here - back : 0);
      else if (pick < 9) w.cell_address = CADDR_W'($urandom_range(0, CELLS - 1));
      else w.cell_address = CADDR_W'($urandom_range(CELLS, 2 ** CADDR_W - 1));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) w.char_byte = CHAR_W'($urandom_range(32, 126));
      else if (pick < 70) w.char_byte = CHAR_W'($urandom_range(127, 255));
      else if (pick < 78) w.char_byte = CH_LF;
      else if (pick < 82) w.char_byte = CH_CR;
      else if (pick < 87) w.char_byte = CH_BS;
      else if (pick < 93) w.char_byte = CH_TAB;
      else w.char_byte = CHAR_W'($urandom_range(0, 31));
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // offer one word and hold it until taken; valid stays high on return
  task automatic offer(in_item_t w, logic use_typed, out_item_t typed_res);
    out_item_t owed;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    owed = console_step(w);
    n_words++;
    console_replies.push_back(use_typed ? typed_res : owed);
  endtask

  // drop valid and wait until every owed result has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (console_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write: setup, then access until pready, then back to idle
  task automatic cfg_write(logic idx, logic [COLOUR_W-1:0] val);
    logic [PDATA_W-1:0] data;
    data = $urandom();
    data[COLOUR_W-1:0] = val;  // upper bits are don't-care noise
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_FG) attr_fg = val;
    else attr_bg = val;
    @(posedge clk);
  endtask

  // bursts of back-to-back words separated by random idle gaps
  task automatic run_stream(int count);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < count; k++) begin
        offer(make_word(), 1'b0, '0);
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [COLOUR_W-1:0] fg_pick;
    logic [COLOUR_W-1:0] bg_pick;
    n_words = 0; n_results = 0; n_scrolls = 0; n_clears = 0;
    n_reads = 0; n_reads_off = 0; n_faults = 0;
    screen_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at reset colours; the DUT is still clearing its store
    // at first, so the first word waits out in_stall
    for (int p = 0; p < PROBES; p++) begin
      for (int r = 0; r < probes[p].reps; r++) begin
        offer(probes[p].word, probes[p].typed && (r == probes[p].reps - 1),
              probes[p].res);
      end
    end

    // random phases, each at its own colour pair; corners first
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0:       begin fg_pick = 4'h0; bg_pick = 4'h0; end
        1:       begin fg_pick = 4'hF; bg_pick = 4'hF; end
        2:       begin fg_pick = 4'hF; bg_pick = 4'h0; end
        3:       begin fg_pick = 4'h0; bg_pick = 4'hF; end
        default: begin
          fg_pick = COLOUR_W'($urandom());
          bg_pick = COLOUR_W'($urandom());
        end
      endcase
      cfg_write(REG_FG, fg_pick);
      cfg_write(REG_BG, bg_pick);
      run_stream(PHASE_WORDS);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d words, %0d results: %0d reads (%0d past the store),",
             n_words, n_results, n_reads, n_reads_off);
    $display("%0d clears, %0d scrolls; colour phases: reset plus %0d settings; %0d faults",
             n_clears, n_scrolls, PHASES, n_faults);
    if (n_faults == 0 && console_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern in segments, with one long hold-off once the
  // run is well under way so the DUT backs up into in_stall.
  // --------------------------------------------------------------------------
  initial begin
    int  mode;
    int  span;
    bit  held;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && n_results >= 300) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(16, 120);
        repeat (span) begin
          case (mode)
            0:       out_stall <= 1'b0;  // no back-pressure at all
            1:       out_stall <= ($urandom_range(0, 99) < 25);
            2:       out_stall <= ($urandom_range(0, 99) < 75);
            default: out_stall <= ($urandom_range(0, 7) == 0) ? ~out_stall : out_stall;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checking: each taken result word against the oldest owed one
  // --------------------------------------------------------------------------
  task automatic log_fault(string why, out_item_t want, out_item_t got);
    n_faults++;
    if (n_faults <= 10) begin
      $display("[%0t] %s: cursor want %0d got %0d, cell want %h got %h",
               $realtime, why, want.cursor_index, got.cursor_index,
               want.cell_word, got.cell_word);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (console_replies.size() == 0) begin
        log_fault("result with nothing owed", '0, out_data);
      end else begin
        want = console_replies.pop_front();
        if (out_data.cursor_index !== want.cursor_index &&
            out_data.cell_word !== want.cell_word)
          log_fault("cursor and cell mismatch", want, out_data);
        else if (out_data.cursor_index !== want.cursor_index)
          log_fault("cursor mismatch", want, out_data);
        else if (out_data.cell_word !== want.cell_word)
          log_fault("cell mismatch", want, out_data);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too many cycles in a row with no word moving on any port
  // --------------------------------------------------------------------------
  int stuck;
  initial stuck = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck >= STUCK_LIMIT) begin
      $display("no progress for %0d cycles, %0d results still owed",
               STUCK_LIMIT, console_replies.size());
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
